// ----- src/longest_unique_byte_run_core_defines.svh -----
// Assertion macros for the longest unique byte run core.
// Used by the port checker; expects clk and rst_n in the scope of use.
`ifndef LONGEST_UNIQUE_BYTE_RUN_CORE_DEFINES_SVH
`define LONGEST_UNIQUE_BYTE_RUN_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LUBR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define LUBR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/lubr_pkg.sv -----
// Shared types and constants for the longest unique byte run core.
// No dependencies.
package lubr_pkg;

  localparam int BYTE_W       = 8;
  localparam int BYTE_VALUES  = 1 << BYTE_W;
  localparam int LEN_W        = 9;
  localparam int START_W      = 16;
  localparam int POS_BITS_DEF = 16;

  // One result item as it leaves the tracker.
  typedef struct packed {
    logic [START_W-1:0] best_start;
    logic [LEN_W-1:0]   best_length;
    logic               string_done;
    logic               overflow;
  } lubr_result_t;

endpackage

// ----- src/lubr_pos_mem.sv -----
// Last-position table: 256 entries, one write and one registered read a cycle.
// Forwards a write to the same entry that lands on the read edge. Uses lubr_pkg.
module lubr_pos_mem #(
  parameter int POSITION_BITS = lubr_pkg::POS_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_en,
  input  logic [lubr_pkg::BYTE_W-1:0] rd_addr,
  output logic [POSITION_BITS-1:0]   rd_data,
  input  logic                       wr_en,
  input  logic [lubr_pkg::BYTE_W-1:0] wr_addr,
  input  logic [POSITION_BITS-1:0]   wr_data
);
  import lubr_pkg::*;

  logic [POSITION_BITS-1:0] mem [BYTE_VALUES];
  logic [POSITION_BITS-1:0] rd_q_r;
  logic [POSITION_BITS-1:0] fwd_data_r;
  logic                     fwd_hit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r     <= mem[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  // read-during-write returns old data; the bypass covers that case
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (rd_en) begin
      fwd_hit_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_hit_r ? fwd_data_r : rd_q_r;

endmodule

// ----- src/lubr_track.sv -----
// Run tracker: seen flags, window start, position and best run.
// Computes one result per fired item and drives the table write. Uses lubr_pkg.
module lubr_track #(
  parameter int POSITION_BITS = lubr_pkg::POS_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  logic [lubr_pkg::BYTE_W-1:0] byte_val,
  input  logic                        is_last,
  input  logic [POSITION_BITS-1:0]    rd_pos,
  output logic                        wr_en,
  output logic [lubr_pkg::BYTE_W-1:0] wr_addr,
  output logic [POSITION_BITS-1:0]    wr_data,
  output lubr_pkg::lubr_result_t      result
);
  import lubr_pkg::*;

  localparam int RunW   = (POSITION_BITS + 1 > LEN_W) ? POSITION_BITS + 1 : LEN_W;
  localparam int StartW = (POSITION_BITS > START_W) ? POSITION_BITS : START_W;

  logic [BYTE_VALUES-1:0]   seen_r;
  logic [POSITION_BITS-1:0] ws_r, ws_nxt;
  logic [POSITION_BITS:0]   pos_r;
  logic [LEN_W-1:0]         best_len_r, best_len_nxt;
  logic [POSITION_BITS-1:0] best_start_r, best_start_nxt;
  logic                     ovf_r;

  logic                     ovf_now;
  logic [POSITION_BITS-1:0] here;
  logic                     hit;
  logic [RunW-1:0]          run;
  logic                     better;
  logic [StartW-1:0]        start_ext;

  assign ovf_now = pos_r[POSITION_BITS];
  assign here    = pos_r[POSITION_BITS-1:0];
  assign hit     = seen_r[byte_val] && (rd_pos >= ws_r);
  assign ws_nxt  = hit ? rd_pos + POSITION_BITS'(1) : ws_r;
  assign run     = RunW'(here) - RunW'(ws_nxt) + RunW'(1);
  assign better  = run > RunW'(best_len_r);

  always_comb begin
    best_len_nxt   = best_len_r;
    best_start_nxt = best_start_r;
    if (!ovf_now && better) begin
      best_len_nxt   = run[LEN_W-1:0];
      best_start_nxt = ws_nxt;
    end
  end

  assign start_ext          = StartW'(best_start_nxt);
  assign result.best_start  = start_ext[START_W-1:0];
  assign result.best_length = best_len_nxt;
  assign result.string_done = is_last;
  assign result.overflow    = ovf_r || ovf_now;

  assign wr_en   = fire && !ovf_now;
  assign wr_addr = byte_val;
  assign wr_data = here;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r       <= '0;
      ws_r         <= '0;
      pos_r        <= '0;
      best_len_r   <= '0;
      best_start_r <= '0;
      ovf_r        <= 1'b0;
    end else if (fire) begin
      if (is_last) begin
        seen_r       <= '0;
        ws_r         <= '0;
        pos_r        <= '0;
        best_len_r   <= '0;
        best_start_r <= '0;
        ovf_r        <= 1'b0;
      end else if (ovf_now) begin
        ovf_r <= 1'b1;
      end else begin
        seen_r[byte_val] <= 1'b1;
        ws_r             <= ws_nxt;
        pos_r            <= pos_r + (POSITION_BITS + 1)'(1);
        best_len_r       <= best_len_nxt;
        best_start_r     <= best_start_nxt;
      end
    end
  end

endmodule

// ----- src/longest_unique_byte_run_core.sv -----
// Longest unique byte run core: takes a string one byte per item (in_is_last
// marks its final byte) and returns, for every byte, the start and length of
// the longest run so far in which no byte value repeats; of equally long runs
// the earliest is kept. Items flow at one per cycle while the output is not
// stalled: the input item's byte addresses the 256-entry last-position table at
// the accept edge, the update stage then updates window and best run from the
// registered read, and the closing edge of its firing cycle writes the table
// back and loads the output register, which drives out_valid. A byte repeated
// in the following item is served by a write bypass around the table, so
// repeats do not slow the stream. The seen flags are flip-flops cleared at
// reset and at the end of each string, so there is no clearing pass. A
// string longer than 2^POSITION_BITS bytes raises out_overflow, after which
// the best run fields are not valid until the string ends; out_best_start
// carries the low 16 bits of the position. Depends on lubr_pkg,
// lubr_pos_mem and lubr_track.
module longest_unique_byte_run_core #(
  parameter int POSITION_BITS = lubr_pkg::POS_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lubr_pkg::BYTE_W-1:0]  in_byte_in,
  input  logic                         in_is_last,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lubr_pkg::START_W-1:0] out_best_start,
  output logic [lubr_pkg::LEN_W-1:0]   out_best_length,
  output logic                         out_string_done,
  output logic                         out_overflow
);
  import lubr_pkg::*;

  // update stage: item whose table read is in flight
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_last_r;

  // output register
  logic              out_valid_r;
  lubr_result_t      out_res_r;

  logic                     in_accept;
  logic                     s1_fire;
  logic [POSITION_BITS-1:0] rd_pos;
  logic                     wr_en;
  logic [BYTE_W-1:0]        wr_addr;
  logic [POSITION_BITS-1:0] wr_data;
  lubr_result_t             res;

  // update stage moves when the output register is free or being drained
  assign s1_fire   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_fire;
  assign in_accept = in_valid && !in_stall;

  lubr_pos_mem #(
    .POSITION_BITS(POSITION_BITS)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_accept),
    .rd_addr (in_byte_in),
    .rd_data (rd_pos),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  lubr_track #(
    .POSITION_BITS(POSITION_BITS)
  ) u_track (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (s1_fire),
    .byte_val (s1_byte_r),
    .is_last  (s1_last_r),
    .rd_pos   (rd_pos),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .result   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r <= in_byte_in;
      s1_last_r <= in_is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_best_start  = out_res_r.best_start;
  assign out_best_length = out_res_r.best_length;
  assign out_string_done = out_res_r.string_done;
  assign out_overflow    = out_res_r.overflow;

endmodule

// ----- src/lubr_checker.sv -----
// Port-level checker for the longest unique byte run core, bound to the top.
// Depends on longest_unique_byte_run_core_defines.svh and lubr_pkg.
`include "longest_unique_byte_run_core_defines.svh"

module lubr_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [lubr_pkg::START_W-1:0] out_best_start,
  input logic [lubr_pkg::LEN_W-1:0]   out_best_length,
  input logic                         out_string_done,
  input logic                         out_overflow
);
  import lubr_pkg::*;

  logic out_take;
  logic new_string_r;

  assign out_take = out_valid && !out_stall;

  // set once a string's last result is taken: the next result opens a string
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      new_string_r <= 1'b1;
    end else if (out_take) begin
      new_string_r <= out_string_done;
    end
  end

  `LUBR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_best_start) && $stable(out_best_length) && $stable(out_string_done) && $stable(out_overflow), "stalled result changed")
  `LUBR_ASSERT_NOW(a_len_range, out_valid, (out_best_length != '0) && (!out_best_length[LEN_W-1] || (out_best_length[LEN_W-2:0] == '0)), "best length outside 1..256")
  `LUBR_ASSERT_NOW(a_first_byte, out_valid && new_string_r, (out_best_length == LEN_W'(1)) && (out_best_start == '0) && !out_overflow, "first result of a string is not a single-byte run")

endmodule

bind longest_unique_byte_run_core lubr_checker u_lubr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_best_start  (out_best_start),
  .out_best_length (out_best_length),
  .out_string_done (out_string_done),
  .out_overflow    (out_overflow)
);
